/* rtl/core/pwsq_pkg.sv */
// Shared types, sizes and helpers for the priority work-stealing queue unit.
// No dependencies; all files in rtl/core but pwsq_ram import this package.
package pwsq_pkg;

  // Sizing of the rings and of the stored handles.
  localparam int QUEUE_DEPTH     = 512;
  localparam int PRIORITY_LEVELS = 4;
  localparam int HANDLE_BITS     = 16;

  // Fixed field widths of the request and result ports.
  localparam int ACTION_W  = 2;
  localparam int PRIO_W    = 2;
  localparam int HANDLE_W  = 16;

  // Derived widths. Pointers count modulo twice the ring depth.
  localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int PRIO_IDX_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int SLOTS      = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int STORE_W    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  // Command queue and result queue sizes.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RES_DEPTH  = 4;
  localparam int RES_IDX_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [PRIO_IDX_W-1:0] prio_idx_t;

  // Request codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_WORK_INSERT = 2'd0,
    ACT_AFF_INSERT  = 2'd1,
    ACT_LOCAL_GET   = 2'd2,
    ACT_STEAL       = 2'd3
  } action_t;

  // Memory operation carried from the front end to the back end.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } mem_op_t;

  // One classified request: memory access plus the result fields known up front.
  typedef struct packed {
    mem_op_t                op;
    logic                   aff;
    logic [ADDR_W-1:0]      addr;
    logic [STORE_W-1:0]     data;
    logic                   ok;
    logic                   src;
    logic [PRIO_W-1:0]      served;
  } cmd_t;

  // One finished result.
  typedef struct packed {
    logic [HANDLE_W-1:0] task_out;
    logic                ok;
    logic                src;
    logic [PRIO_W-1:0]   served;
  } result_t;

  // Flat store address of a ring slot: priority selects the ring, pointer the slot.
  function automatic logic [ADDR_W-1:0] slot_addr(input prio_idx_t prio, input ptr_t ptr);
    logic [SLOT_W-1:0] low;
    low = ptr[SLOT_W-1:0];
    return ADDR_W'({prio, low});
  endfunction

endpackage

/* rtl/core/pwsq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pwsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/pwsq_front.sv */
// Front end: holds the ring pointers, classifies each request and emits a command.
// Depends on pwsq_pkg.
module pwsq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [pwsq_pkg::ACTION_W-1:0] in_action,
  input  logic [pwsq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [pwsq_pkg::HANDLE_W-1:0] in_task_handle,
  output pwsq_pkg::cmd_t                cmd
);
  import pwsq_pkg::*;

  ptr_t w_head_r [PRIORITY_LEVELS];
  ptr_t w_tail_r [PRIORITY_LEVELS];
  ptr_t a_head_r [PRIORITY_LEVELS];
  ptr_t a_tail_r [PRIORITY_LEVELS];
  ptr_t w_head_nxt [PRIORITY_LEVELS];
  ptr_t w_tail_nxt [PRIORITY_LEVELS];
  ptr_t a_head_nxt [PRIORITY_LEVELS];
  ptr_t a_tail_nxt [PRIORITY_LEVELS];

  logic [PRIORITY_LEVELS-1:0] w_nonempty, a_nonempty, w_full, a_full;
  prio_idx_t w_best, a_best, pr;
  logic      w_any, a_any, use_work, prio_ok;

  // Per-ring status from the pointer difference.
  always_comb begin
    for (int p = 0; p < PRIORITY_LEVELS; p++) begin
      w_nonempty[p] = (w_head_r[p] != w_tail_r[p]);
      a_nonempty[p] = (a_head_r[p] != a_tail_r[p]);
      w_full[p]     = (ptr_t'(w_head_r[p] - w_tail_r[p]) == ptr_t'(QUEUE_DEPTH));
      a_full[p]     = (ptr_t'(a_head_r[p] - a_tail_r[p]) == ptr_t'(QUEUE_DEPTH));
    end
  end

  // Lowest-numbered non-empty priority of each queue.
  always_comb begin
    w_best = '0;
    a_best = '0;
    for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
      if (w_nonempty[p]) begin
        w_best = prio_idx_t'(p);
      end
      if (a_nonempty[p]) begin
        a_best = prio_idx_t'(p);
      end
    end
    w_any = |w_nonempty;
    a_any = |a_nonempty;
  end

  assign pr       = prio_idx_t'(in_priority_req);
  assign prio_ok  = (int'(in_priority_req) < PRIORITY_LEVELS);
  // The work queue serves a local get only when it is strictly better.
  assign use_work = w_any && (!a_any || (w_best < a_best));

  // Classification and pointer updates.
  always_comb begin
    ptr_t ptr;
    ptr        = '0;
    w_head_nxt = w_head_r;
    w_tail_nxt = w_tail_r;
    a_head_nxt = a_head_r;
    a_tail_nxt = a_tail_r;
    cmd.op     = OP_NOP;
    cmd.aff    = 1'b0;
    cmd.addr   = '0;
    cmd.data   = STORE_W'(in_task_handle);
    cmd.ok     = 1'b0;
    cmd.src    = 1'b0;
    cmd.served = '0;
    if (accept) begin
      case (action_t'(in_action))
        ACT_WORK_INSERT: begin
          if (prio_ok && !w_full[pr]) begin
            cmd.op         = OP_WRITE;
            cmd.addr       = slot_addr(pr, w_head_r[pr]);
            cmd.ok         = 1'b1;
            w_head_nxt[pr] = ptr_t'(w_head_r[pr] + 1'b1);
          end
        end
        ACT_AFF_INSERT: begin
          if (prio_ok && !a_full[pr]) begin
            cmd.op         = OP_WRITE;
            cmd.aff        = 1'b1;
            cmd.addr       = slot_addr(pr, a_head_r[pr]);
            cmd.ok         = 1'b1;
            a_head_nxt[pr] = ptr_t'(a_head_r[pr] + 1'b1);
          end
        end
        ACT_LOCAL_GET: begin
          if (use_work) begin
            // Newest work item first: pop the head.
            ptr                = ptr_t'(w_head_r[w_best] - 1'b1);
            cmd.op             = OP_READ;
            cmd.addr           = slot_addr(w_best, ptr);
            cmd.ok             = 1'b1;
            cmd.served         = PRIO_W'(w_best);
            w_head_nxt[w_best] = ptr;
          end else if (a_any) begin
            // Affinity items go oldest first: pop the tail.
            cmd.op             = OP_READ;
            cmd.aff            = 1'b1;
            cmd.addr           = slot_addr(a_best, a_tail_r[a_best]);
            cmd.ok             = 1'b1;
            cmd.src            = 1'b1;
            cmd.served         = PRIO_W'(a_best);
            a_tail_nxt[a_best] = ptr_t'(a_tail_r[a_best] + 1'b1);
          end
        end
        ACT_STEAL: begin
          if (w_any) begin
            cmd.op             = OP_READ;
            cmd.addr           = slot_addr(w_best, w_tail_r[w_best]);
            cmd.ok             = 1'b1;
            cmd.served         = PRIO_W'(w_best);
            w_tail_nxt[w_best] = ptr_t'(w_tail_r[w_best] + 1'b1);
          end
        end
        default: begin
          cmd.op = OP_NOP;
        end
      endcase
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PRIORITY_LEVELS; p++) begin
        w_head_r[p] <= '0;
        w_tail_r[p] <= '0;
        a_head_r[p] <= '0;
        a_tail_r[p] <= '0;
      end
    end else begin
      w_head_r <= w_head_nxt;
      w_tail_r <= w_tail_nxt;
      a_head_r <= a_head_nxt;
      a_tail_r <= a_tail_nxt;
    end
  end

  // A successful work insert never lands in a ring that was full.
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WRITE && !cmd.aff) |-> !w_full[pr])
    else $error("work insert into full ring");

  // A read is only issued when some ring of that queue holds an item.
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_READ) |-> (cmd.aff ? a_any : w_any))
    else $error("read issued from empty queue");

  // A read always reports success.
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_READ) |-> cmd.ok)
    else $error("read command without success");

endmodule

/* rtl/core/pwsq_cmdq.sv */
// Short command queue between the front end and the back end.
// Depends on pwsq_pkg.
module pwsq_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pwsq_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pwsq_pkg::cmd_t cmd_out
);
  import pwsq_pkg::*;

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = entry_r[rptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wptr_nxt  = do_push ? CMDQ_IDX_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = do_pop ? CMDQ_IDX_W'(rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CMDQ_CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CMDQ_CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/pwsq_back.sv */
// Back end: executes commands on the two task stores and queues the results.
// Depends on pwsq_pkg and pwsq_ram.
module pwsq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  input  pwsq_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  input  logic            res_pop,
  output logic            res_empty,
  output pwsq_pkg::result_t res
);
  import pwsq_pkg::*;

  logic                 issue;
  logic                 w_we, a_we, w_re, a_re;
  logic [STORE_W-1:0]   w_rdata, a_rdata, rd_sel;
  logic                 stg_vld_r;
  cmd_t                 stg_r;
  result_t              stg_res;
  result_t              res_r [RES_DEPTH];
  logic [RES_IDX_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic                 do_pop;

  // Issue a command only when the result queue has room for it and the one in flight.
  assign issue   = !cmd_empty &&
                   (RES_CNT_W'(count_r + RES_CNT_W'(stg_vld_r)) < RES_CNT_W'(RES_DEPTH));
  assign cmd_pop = issue;

  assign w_we = issue && (cmd.op == OP_WRITE) && !cmd.aff;
  assign a_we = issue && (cmd.op == OP_WRITE) && cmd.aff;
  assign w_re = issue && (cmd.op == OP_READ) && !cmd.aff;
  assign a_re = issue && (cmd.op == OP_READ) && cmd.aff;

  pwsq_ram #(.WIDTH(STORE_W), .DEPTH(SLOTS)) u_work_store (
    .clk   (clk),
    .we    (w_we),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .re    (w_re),
    .raddr (cmd.addr),
    .rdata (w_rdata)
  );

  pwsq_ram #(.WIDTH(STORE_W), .DEPTH(SLOTS)) u_affinity_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .re    (a_re),
    .raddr (cmd.addr),
    .rdata (a_rdata)
  );

  // Stage that waits for the registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stg_r <= cmd;
    end
  end

  // Build the result; only a read returns a handle.
  always_comb begin
    rd_sel           = stg_r.aff ? a_rdata : w_rdata;
    stg_res.task_out = (stg_r.op == OP_READ) ? HANDLE_W'(rd_sel) : '0;
    stg_res.ok       = stg_r.ok;
    stg_res.src      = stg_r.src;
    stg_res.served   = stg_r.served;
  end

  // Result queue.
  assign res_empty = (count_r == '0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = res_r[rptr_r];

  always_comb begin
    wptr_nxt  = stg_vld_r ? RES_IDX_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = do_pop ? RES_IDX_W'(rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r;
    if (stg_vld_r && !do_pop) begin
      count_nxt = RES_CNT_W'(count_r + 1'b1);
    end else if (do_pop && !stg_vld_r) begin
      count_nxt = RES_CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_r) begin
      res_r[wptr_r] <= stg_res;
    end
  end

  // The result queue never overflows.
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (RES_CNT_W'(count_r + RES_CNT_W'(stg_vld_r)) <= RES_CNT_W'(RES_DEPTH)))
    else $error("result queue overflow");

  // A waiting result stays until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!res_empty && !res_pop) |=> !res_empty)
    else $error("result lost without a pop");

  // A failed operation never returns a handle.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !stg_r.ok) |-> (stg_res.task_out == '0))
    else $error("failed operation returned a handle");

endmodule

/* rtl/core/priority_work_stealing_queues.sv */
// Path: command queue, task-store read or write into the stage, then result queue.
// Throughput: one request per cycle, set by the single access each request makes
// to its task store; in_full rises only when the result side has stalled.
// Reset: ring pointers and both internal queues clear at once; the task stores
// are not cleared, and only slots already written are ever read.
module priority_work_stealing_queues (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pwsq_pkg::ACTION_W-1:0] in_action,
  input  logic [pwsq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [pwsq_pkg::HANDLE_W-1:0] in_task_handle,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [pwsq_pkg::HANDLE_W-1:0] out_task_out,
  output logic                          out_success,
  output logic                          out_source_queue,
  output logic [pwsq_pkg::PRIO_W-1:0]   out_served_priority
);
  import pwsq_pkg::*;

  logic    accept;
  cmd_t    front_cmd, back_cmd;
  logic    cmdq_empty, cmdq_pop;
  result_t res;

  assign accept = in_push && !in_full;

  pwsq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_action       (in_action),
    .in_priority_req (in_priority_req),
    .in_task_handle  (in_task_handle),
    .cmd             (front_cmd)
  );

  pwsq_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .cmd_in  (front_cmd),
    .full    (in_full),
    .pop     (cmdq_pop),
    .empty   (cmdq_empty),
    .cmd_out (back_cmd)
  );

  pwsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmdq_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  // Result fields.
  assign out_task_out        = res.task_out;
  assign out_success         = res.ok;
  assign out_source_queue    = res.src;
  assign out_served_priority = res.served;

endmodule

/* verif/tb_priority_work_stealing_queues.sv */
// Testbench for priority_work_stealing_queues: it sends queue requests through push/full,
// keeps its own model of the rings and checks every result transfer taken at empty/pop.
// Depends on pwsq_pkg and the priority_work_stealing_queues top level from rtl/core.
module tb_priority_work_stealing_queues;
  timeunit 1ns;
  timeprecision 1ps;
  import pwsq_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int STALL_CYCLES     = 40;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int DRAIN_CYCLES     = 10;
  localparam int FILL_LEVEL       = PRIORITY_LEVELS - 1;
  localparam logic SRC_WORK       = 1'b0;
  localparam logic SRC_AFFINITY   = 1'b1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [ACTION_W-1:0] in_action;
  logic [PRIO_W-1:0]   in_priority_req;
  logic [HANDLE_W-1:0] in_task_handle;
  logic                out_empty;
  logic                out_pop;
  logic [HANDLE_W-1:0] out_task_out;
  logic                out_success;
  logic                out_source_queue;
  logic [PRIO_W-1:0]   out_served_priority;

  // Shared control between the request side and the result side. The request side
  // counts up stall_requests; the result side starts one long hold for each new count.
  bit idle_en        = 1'b1;
  int stall_requests = 0;

  // Model of the rings: handle stores and per-level head and tail pointers.
  logic [STORE_W-1:0] work_mem [SLOTS];
  logic [STORE_W-1:0] aff_mem  [SLOTS];
  ptr_t work_hd [PRIORITY_LEVELS];
  ptr_t work_tl [PRIORITY_LEVELS];
  ptr_t aff_hd  [PRIORITY_LEVELS];
  ptr_t aff_tl  [PRIORITY_LEVELS];

  // Results the unit still owes, oldest first.
  result_t owed_results [$];

  int sent_count     = 0;
  int results_seen   = 0;
  int rejected_count = 0;
  int full_stalls    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  priority_work_stealing_queues dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_action           (in_action),
    .in_priority_req     (in_priority_req),
    .in_task_handle      (in_task_handle),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_task_out        (out_task_out),
    .out_success         (out_success),
    .out_source_queue    (out_source_queue),
    .out_served_priority (out_served_priority)
  );

  always #5 clk = ~clk;

  // Pointers wrap at twice the ring depth, so the difference is the fill level.
  function automatic int ring_fill(ptr_t hd, ptr_t tl);
    return int'(ptr_t'(hd - tl));
  endfunction

  function automatic int ring_slot(int level, ptr_t ptr);
    return level * QUEUE_DEPTH + int'(ptr) % QUEUE_DEPTH;
  endfunction

  // Lowest-numbered level holding a task, or PRIORITY_LEVELS when every ring is empty.
  function automatic int best_level(logic aff);
    for (int p = 0; p < PRIORITY_LEVELS; p++) begin
      if (aff ? ring_fill(aff_hd[p], aff_tl[p]) != 0 : ring_fill(work_hd[p], work_tl[p]) != 0)
        return p;
    end
    return PRIORITY_LEVELS;
  endfunction

  // Applies one request to the model and returns the result the unit must produce.
  function automatic result_t apply_queue_op(action_t act, logic [PRIO_W-1:0] prio,
                                             logic [HANDLE_W-1:0] handle);
    result_t            res;
    int                 lvl;
    int                 wl;
    int                 al;
    logic [STORE_W-1:0] stored;
    res    = '0;
    stored = handle[STORE_W-1:0];
    lvl    = int'(prio);
    wl     = best_level(SRC_WORK);
    al     = best_level(SRC_AFFINITY);
    case (act)
      ACT_WORK_INSERT: begin
        if (lvl < PRIORITY_LEVELS && ring_fill(work_hd[lvl], work_tl[lvl]) < QUEUE_DEPTH) begin
          work_mem[ring_slot(lvl, work_hd[lvl])] = stored;
          work_hd[lvl] = work_hd[lvl] + 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_AFF_INSERT: begin
        if (lvl < PRIORITY_LEVELS && ring_fill(aff_hd[lvl], aff_tl[lvl]) < QUEUE_DEPTH) begin
          aff_mem[ring_slot(lvl, aff_hd[lvl])] = stored;
          aff_hd[lvl] = aff_hd[lvl] + 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_LOCAL_GET: begin
        // The work queue wins only with a strictly better level; ties go to affinity.
        if (wl < al) begin
          work_hd[wl]  = work_hd[wl] - 1'b1;
          res.task_out = HANDLE_W'(work_mem[ring_slot(wl, work_hd[wl])]);
          res.ok       = 1'b1;
          res.src      = SRC_WORK;
          res.served   = PRIO_W'(wl);
        end else if (al < PRIORITY_LEVELS) begin
          res.task_out = HANDLE_W'(aff_mem[ring_slot(al, aff_tl[al])]);
          aff_tl[al]   = aff_tl[al] + 1'b1;
          res.ok       = 1'b1;
          res.src      = SRC_AFFINITY;
          res.served   = PRIO_W'(al);
        end
      end
      default: begin
        // A steal takes the oldest task of the best work level.
        if (wl < PRIORITY_LEVELS) begin
          res.task_out = HANDLE_W'(work_mem[ring_slot(wl, work_tl[wl])]);
          work_tl[wl]  = work_tl[wl] + 1'b1;
          res.ok       = 1'b1;
          res.src      = SRC_WORK;
          res.served   = PRIO_W'(wl);
        end
      end
    endcase
    return res;
  endfunction

  // Offers one request, waits for its transfer and records the expected result.
  task automatic send_request(action_t act, logic [PRIO_W-1:0] prio,
                              logic [HANDLE_W-1:0] handle);
    int      gap;
    result_t res;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_action       <= act;
    in_priority_req <= prio;
    in_task_handle  <= handle;
    do begin
      @(posedge clk);
      if (in_full) full_stalls++;
    end while (in_full);
    res = apply_queue_op(act, prio, handle);
    if ((act == ACT_WORK_INSERT || act == ACT_AFF_INSERT) && !res.ok) rejected_count++;
    owed_results = {owed_results, res};
    sent_count++;
  endtask

  // Random request; insert_pct sets the share of inserts against gets and steals.
  task automatic send_random_request(int insert_pct);
    action_t act;
    if ($urandom_range(0, 99) < insert_pct)
      act = ($urandom_range(0, 1) == 0) ? ACT_WORK_INSERT : ACT_AFF_INSERT;
    else
      act = ($urandom_range(0, 2) == 0) ? ACT_STEAL : ACT_LOCAL_GET;
    send_request(act, PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1)), HANDLE_W'($urandom()));
  endtask

  // Stops offering requests until every owed result has been transferred.
  task automatic wait_for_results();
    in_push <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Gets and steals on a unit that holds nothing.
  task automatic test_empty_queues();
    send_request(ACT_LOCAL_GET, PRIO_W'($urandom_range(0, 3)), HANDLE_W'($urandom()));
    send_request(ACT_STEAL, PRIO_W'($urandom_range(0, 3)), HANDLE_W'($urandom()));
  endtask

  // Work queue pops its head on a local get and its tail on a steal; affinity is FIFO.
  task automatic test_insert_order();
    send_request(ACT_WORK_INSERT, 2'd0, 16'h0000);
    send_request(ACT_WORK_INSERT, 2'd0, 16'hFFFF);
    send_request(ACT_WORK_INSERT, 2'd0, 16'h5A5A);
    send_request(ACT_LOCAL_GET, 2'd3, 16'hFFFF);
    send_request(ACT_STEAL, 2'd3, 16'hFFFF);
    send_request(ACT_STEAL, 2'd0, 16'h0000);
    send_request(ACT_AFF_INSERT, 2'd3, 16'h1234);
    send_request(ACT_AFF_INSERT, 2'd3, 16'hEDCB);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
  endtask

  // Level selection between the two queues, including the tie that favors affinity.
  task automatic test_priority_select();
    send_request(ACT_WORK_INSERT, 2'd2, 16'hA5A5);
    send_request(ACT_AFF_INSERT, 2'd1, 16'h0F0F);
    send_request(ACT_AFF_INSERT, 2'd2, 16'hF0F0);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
    send_request(ACT_WORK_INSERT, 2'd0, 16'h8001);
    send_request(ACT_AFF_INSERT, 2'd0, 16'h7FFE);
    send_request(ACT_STEAL, 2'd0, 16'h0000);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
    send_request(ACT_WORK_INSERT, 2'd1, 16'h3C3C);
    send_request(ACT_LOCAL_GET, 2'd0, 16'h0000);
  endtask

  // Fills one ring of each queue to the brim, then checks rejection and slot reuse.
  task automatic test_ring_full();
    for (int i = 0; i < 2 * (QUEUE_DEPTH + 2); i++)
      send_request((i % 2 == 0) ? ACT_WORK_INSERT : ACT_AFF_INSERT, PRIO_W'(FILL_LEVEL),
                   HANDLE_W'($urandom()));
    send_request(ACT_STEAL, 2'd0, 16'h0000);
    send_request(ACT_WORK_INSERT, PRIO_W'(FILL_LEVEL), 16'hBEEF);
    send_request(ACT_WORK_INSERT, PRIO_W'(FILL_LEVEL), 16'hDEAD);
  endtask

  // Result side holds off for a long stretch so the unit backs up and raises full,
  // then the sender pauses until all owed results are out.
  task automatic test_backpressure();
    idle_en = 1'b0;
    stall_requests++;
    for (int i = 0; i < 30; i++) send_random_request(50);
    wait_for_results();
    idle_en = 1'b1;
  endtask

  // Random traffic in blocks, each block with or without idling on both sides.
  task automatic test_random_mix();
    for (int blk = 0; blk < 6; blk++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) send_random_request(45);
    end
    idle_en = 1'b1;
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    for (int i = 0; i < 100; i++) send_random_request(50);
  endtask

  // Result side: checks each transfer and decides on pop for the next cycle.
  initial begin : result_monitor
    result_t want;
    int      hold_left;
    int      burst_left;
    int      stalls_taken;
    hold_left    = 0;
    burst_left   = 0;
    stalls_taken = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: result transfer with nothing owed: task=%h ok=%b src=%b prio=%0d",
                     $time, out_task_out, out_success, out_source_queue,
                     out_served_priority);
        end else begin
          want = owed_results.pop_front();
          if (out_task_out !== want.task_out || out_success !== want.ok ||
              out_source_queue !== want.src || out_served_priority !== want.served) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
              $display("%0t: mismatch: expected task=%h ok=%b src=%b prio=%0d, %s%h %s%b %s%b %s%0d",
                       $time, want.task_out, want.ok, want.src, want.served,
                       "got task=", out_task_out, "ok=", out_success,
                       "src=", out_source_queue, "prio=", out_served_priority);
          end
        end
      end
      if (stall_requests != stalls_taken) begin
        stalls_taken++;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results still owed", cycle_count,
             owed_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_action       = ACT_WORK_INSERT;
    in_priority_req = '0;
    in_task_handle  = '0;
    for (int p = 0; p < PRIORITY_LEVELS; p++) begin
      work_hd[p] = '0;
      work_tl[p] = '0;
      aff_hd[p]  = '0;
      aff_tl[p]  = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queues();
    test_insert_order();
    test_priority_select();
    test_ring_full();
    test_backpressure();
    test_random_mix();
    test_back_to_back();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d result transfers: empty, order, level and",
             sent_count, results_seen);
    $display("full-ring cases, %0d rejected inserts, %0d cycles with the input held off.",
             rejected_count, full_stalls);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failing result transfers", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
